// File: rtl/core/sprf_pkg.sv
`timescale 1ns / 1ps
package sprf_pkg;

    // Fixed datapath widths
    localparam int ACC_W   = 48;
    localparam int PT_W    = 32;
    localparam int PROD_W  = 64;

    // Quotient saturation bound, 2^40
    localparam logic [40:0] Q_LIM = 41'h100_0000_0000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_POLY_DEGREE = 2'd0,
        CFG_TOLERANCE   = 2'd1,
        CFG_MAX_ITER    = 2'd2
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_CONVERGED  = 2'd0,
        ST_ITER_LIMIT = 2'd1,
        ST_ZERO_DEN   = 2'd2
    } t_status;

    // Input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

endpackage

// File: rtl/core/secant_polynomial_root_finder_core.sv
`timescale 1ns / 1ps
// Secant-method polynomial root finder, signed Q16.16.
// Input channel (i_in_valid / o_in_stall): a load transfer (cmd 0) writes one
// coefficient and gives no result; a start transfer (cmd 1)
// brings two initial guesses and gives exactly one result.
// Output channel (o_out_valid / i_out_stall): root estimate, step count and
// status, held in an output register until taken.
// A start runs secant steps at the configured degree; a step that finds a
// zero denominator ends after its evaluations.
// One shared 32x32 multiplier paces it: two passes per Horner step
// (S_MHI, S_MLO, then S_ADD), one pass for the numerator, one for the
// tolerance test, and a radix-2 divider that forms a 64-bit quotient per step. Throughput is one start at
// a time; o_in_stall is high while a search runs.
// A finished result waits in the output register while the receiver stalls;
// new loads and starts are taken meanwhile, and a later search holds its
// result until the register is free.
// Reset (synchronous, active low) clears the coefficient store, restores the
// configuration defaults (degree 2, tolerance 33, limit 64) and empties the
// output register.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
module secant_polynomial_root_finder_core
    import sprf_pkg::*;
#(
    parameter int MAX_DEGREE = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [3:0]         i_coef_index,
    input  logic signed [15:0] i_coef_value,
    input  logic signed [31:0] i_guess_first,
    input  logic signed [31:0] i_guess_second,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_root_estimate,
    output logic [7:0]         o_iterations_used,
    output logic [1:0]         o_search_status
);

    localparam int IW = $clog2(MAX_DEGREE + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MHI  = 10'b0000000010,
        S_MLO  = 10'b0000000100,
        S_ADD  = 10'b0000001000,
        S_DEN  = 10'b0000010000,
        S_NUM  = 10'b0000100000,
        S_DIV  = 10'b0001000000,
        S_UPD  = 10'b0010000000,
        S_CHK  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state;

    // Configuration
    logic [3:0]  r_degree;
    logic [15:0] r_tol;
    logic [7:0]  r_max_iter;

    logic signed [15:0] r_coef [MAX_DEGREE+1];

    // Search state
    logic signed [PT_W-1:0]  r_x1, r_x2, r_x3;
    logic signed [PT_W-1:0]  r_f1;
    logic signed [ACC_W-1:0] r_acc;
    logic [IW-1:0]           r_idx;
    logic                    r_sel;
    logic [7:0]              r_count;
    logic [1:0]              r_status;
    logic [PROD_W-1:0]       r_prod, r_phi;
    logic [31:0]             r_den;
    logic                    r_qneg;
    logic [PROD_W-1:0]       r_quo;
    logic [32:0]             r_rem;
    logic [5:0]              r_div_cnt;
    logic [32:0]             r_diff;
    logic                    r_chk;

    logic               r_out_valid;
    logic signed [31:0] r_out_root;
    logic [7:0]         r_out_count;
    logic [1:0]         r_out_status;

    // Shared datapath signals
    logic signed [PT_W-1:0]  cur_x;
    logic [31:0]             x_mag;
    logic [ACC_W-1:0]        acc_mag;
    logic [31:0]             mul_a, mul_b;
    logic [IW-1:0]           deg_idx;
    logic signed [65:0]      add_m, add_sum;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [PT_W-1:0]  f_cur;
    logic signed [32:0]      den_s, dx_s;
    logic [31:0]             f2_mag, dx_mag;
    logic [33:0]             rem_sh, rem_sub;
    logic [40:0]             q_mag;
    logic signed [42:0]      x3_wide;
    logic signed [PT_W-1:0]  x3_sat;
    logic signed [32:0]      dif_s;
    logic                    in_xfer, start_ok;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign start_ok = in_xfer && (i_cmd == CMD_START);
    assign o_in_stall = (r_state != S_IDLE);

    assign o_out_valid       = r_out_valid;
    assign o_root_estimate   = r_out_root;
    assign o_iterations_used = r_out_count;
    assign o_search_status   = r_out_status;

    // Clamp configured degree to the store depth
    always_comb begin
        if (32'(r_degree) > 32'(MAX_DEGREE)) begin
            deg_idx = IW'(MAX_DEGREE);
        end else begin
            deg_idx = IW'(r_degree);
        end
    end

    // Horner operands
    assign cur_x   = r_sel ? r_x2 : r_x1;
    assign x_mag   = cur_x[PT_W-1] ? 32'(-cur_x) : 32'(cur_x);
    assign acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    // Secant operands
    assign den_s  = 33'(r_x1) - 33'(r_x1) + 33'(f_cur) - 33'(r_f1);
    assign dx_s   = 33'(r_x2) - 33'(r_x1);
    assign f2_mag = f_cur[PT_W-1] ? 32'(-33'(f_cur)) : 32'(f_cur);
    assign dx_mag = dx_s[32] ? 32'(-dx_s) : 32'(dx_s);

    // Select multiplier operands
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_MHI: begin
                mul_a = acc_mag[47:16];
                mul_b = x_mag;
            end
            S_MLO: begin
                mul_a = {16'd0, acc_mag[15:0]};
                mul_b = x_mag;
            end
            S_DEN: begin
                mul_a = f2_mag;
                mul_b = dx_mag;
            end
            S_CHK: begin
                mul_a = {16'd0, r_tol};
                mul_b = r_x2[PT_W-1] ? 32'(-33'(r_x2)) : 32'(r_x2);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Horner accumulate and saturate
    always_comb begin
        add_m = 66'(r_phi) + 66'(r_prod >> 16);
        if (r_acc[ACC_W-1] ^ cur_x[PT_W-1]) begin
            add_m = -add_m;
        end
        add_sum = add_m + (66'(r_coef[r_idx]) <<< 16);
        if (add_sum > 66'sh7FFF_FFFF_FFFF) begin
            acc_next = 48'sh7FFF_FFFF_FFFF;
        end else if (add_sum < -66'sh8000_0000_0000) begin
            acc_next = -48'sh8000_0000_0000;
        end else begin
            acc_next = ACC_W'(add_sum);
        end
    end

    // Final value saturated to 32 bits
    always_comb begin
        if (r_acc > 48'sh0000_7FFF_FFFF) begin
            f_cur = 32'sh7FFF_FFFF;
        end else if (r_acc < -48'sh0000_8000_0000) begin
            f_cur = -32'sh8000_0000;
        end else begin
            f_cur = PT_W'(r_acc);
        end
    end

    // Restoring divide step
    assign rem_sh  = {r_rem, r_quo[PROD_W-1]};
    assign rem_sub = rem_sh - 34'(r_den);

    // Next estimate
    always_comb begin
        q_mag = (r_quo > 64'(Q_LIM)) ? Q_LIM : r_quo[40:0];
        x3_wide = 43'(r_x2) - (r_qneg ? -43'(q_mag) : 43'(q_mag));
        if (x3_wide > 43'sh0_7FFF_FFFF) begin
            x3_sat = 32'sh7FFF_FFFF;
        end else if (x3_wide < -43'sh0_8000_0000) begin
            x3_sat = -32'sh8000_0000;
        end else begin
            x3_sat = PT_W'(x3_wide);
        end
        dif_s = 33'(x3_sat) - 33'(r_x2);
    end

    // Configuration and coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree   <= 4'd2;
            r_tol      <= 16'd33;
            r_max_iter <= 8'd64;
            for (int i = 0; i <= MAX_DEGREE; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLY_DEGREE: r_degree   <= i_cfg_data[3:0];
                    CFG_TOLERANCE:   r_tol      <= i_cfg_data;
                    CFG_MAX_ITER:    r_max_iter <= i_cfg_data[7:0];
                    default:         ;
                endcase
            end
            if (in_xfer && i_cmd == CMD_LOAD && 32'(i_coef_index) <= 32'(MAX_DEGREE)) begin
                r_coef[IW'(i_coef_index)] <= i_coef_value;
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
            // Load a finished result, or drop the one just taken
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (start_ok) begin
                        r_x1     <= i_guess_first;
                        r_x2     <= i_guess_second;
                        r_x3     <= i_guess_second;
                        r_count  <= 8'd0;
                        r_status <= ST_ITER_LIMIT;
                        r_sel    <= 1'b0;
                        r_acc    <= '0;
                        r_idx    <= deg_idx;
                        r_state  <= (r_max_iter == 8'd0) ? S_DONE : S_MHI;
                    end
                end
                S_MHI: r_state <= S_MLO;
                S_MLO: begin
                    r_phi   <= r_prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_idx == '0) begin
                        r_state <= r_sel ? S_DEN : S_MHI;
                        if (!r_sel) begin
                            r_sel <= 1'b1;
                            r_idx <= deg_idx;
                        end
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_MHI;
                    end
                    if (r_idx == '0 && !r_sel) begin
                        // first point done, restart for the second
                        r_f1  <= PT_W'(acc_next > 48'sh0000_7FFF_FFFF ? 48'sh0000_7FFF_FFFF :
                                       acc_next < -48'sh0000_8000_0000 ?
                                       -48'sh0000_8000_0000 : acc_next);
                        r_acc <= '0;
                    end else begin
                        r_acc <= acc_next;
                    end
                end
                S_DEN: begin
                    if (den_s == 33'sd0) begin
                        r_x3     <= r_x2;
                        r_status <= ST_ZERO_DEN;
                        r_state  <= S_DONE;
                    end else begin
                        r_den   <= den_s[32] ? 32'(-den_s) : 32'(den_s);
                        r_qneg  <= f_cur[PT_W-1] ^ dx_s[32] ^ den_s[32];
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_quo     <= r_prod;
                    r_rem     <= '0;
                    r_div_cnt <= 6'd63;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    if (rem_sub[33]) begin
                        r_rem <= rem_sh[32:0];
                        r_quo <= {r_quo[PROD_W-2:0], 1'b0};
                    end else begin
                        r_rem <= rem_sub[32:0];
                        r_quo <= {r_quo[PROD_W-2:0], 1'b1};
                    end
                    if (r_div_cnt == 6'd0) begin
                        r_state <= S_UPD;
                    end else begin
                        r_div_cnt <= r_div_cnt - 1'b1;
                    end
                end
                S_UPD: begin
                    r_x3    <= x3_sat;
                    r_x1    <= r_x2;
                    r_x2    <= x3_sat;
                    r_count <= r_count + 1'b1;
                    r_diff  <= dif_s[32] ? 33'(-dif_s) : 33'(dif_s);
                    r_chk   <= 1'b0;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // the product loads while r_chk is clear, then the compare runs
                    r_chk <= 1'b1;
                    if (r_chk) begin
                        if (64'({r_diff, 16'h0000}) <= r_prod) begin
                            r_status <= ST_CONVERGED;
                            r_state  <= S_DONE;
                        end else if (r_count == r_max_iter) begin
                            r_status <= ST_ITER_LIMIT;
                            r_state  <= S_DONE;
                        end else begin
                            r_sel   <= 1'b0;
                            r_acc   <= '0;
                            r_idx   <= deg_idx;
                            r_state <= S_MHI;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_root   <= r_x3;
                        r_out_count  <= r_count;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
